### rtl/core/pmm_pkg.sv
// Package for pile_merge_min_cost: shared constants and the control structs
// passed between the sequencer, the arithmetic unit and the top level.
// No dependencies.
package pmm_pkg;

  localparam int MAX_PILES_DEF = 64;
  localparam int WEIGHT_W      = 16;
  localparam int COST_W        = 32;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef struct packed {
    logic tot;
    logic wrap;
    logic acc;
    logic first;
    logic za;
    logic zb;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic res_load;
    logic single;
  } seq_stat_t;

endpackage

### rtl/core/pmm_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module pmm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [W-1:0]  rdata0,
  output logic [W-1:0]  rdata1
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd0_r;
  logic [W-1:0] rd1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

### rtl/core/pmm_alu.sv
// Shared arithmetic unit: run total from prefix sums, split-cost add and
// running minimum, saturating cost write-back. Depends on pmm_pkg.
module pmm_alu #(
  parameter int PSW = 22
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pmm_pkg::alu_ctl_t          ctl,
  input  logic [PSW-1:0]             p_start,
  input  logic [PSW-1:0]             p_end,
  input  logic [PSW-1:0]             sum,
  input  logic [pmm_pkg::COST_W-1:0] c_a,
  input  logic [pmm_pkg::COST_W-1:0] c_b,
  output logic [pmm_pkg::COST_W-1:0] wdata,
  output logic [pmm_pkg::COST_W-1:0] best
);

  localparam int CWD = pmm_pkg::COST_W;

  pmm_pkg::alu_ctl_t ctl_d_r;
  logic [PSW-1:0]    total_r;
  logic [PSW-1:0]    total_nxt;
  logic [PSW-1:0]    end_v;
  logic [CWD:0]      min_r;
  logic [CWD:0]      pair;
  logic [CWD+1:0]    ext;

  always_comb begin
    end_v     = ctl_d_r.wrap ? (p_end + sum) : p_end;
    total_nxt = end_v - p_start;
    pair      = {1'b0, (ctl_d_r.za ? '0 : c_a)} + {1'b0, (ctl_d_r.zb ? '0 : c_b)};
    ext       = (CWD+2)'(min_r) + (CWD+2)'(total_r);
    wdata     = (ext > (CWD+2)'(pmm_pkg::COST_MAX)) ? pmm_pkg::COST_MAX : ext[CWD-1:0];
    best      = min_r[CWD-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r <= '0;
    end else begin
      ctl_d_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_d_r.tot) begin
      total_r <= total_nxt;
    end
    if (ctl_d_r.acc && (ctl_d_r.first || pair < min_r)) begin
      min_r <= pair;
    end
  end

endmodule

### rtl/core/pmm_seq.sv
// Sequencer: walks interval length, start pile and split point, drives the
// prefix and cost table addresses and the shared unit. Depends on pmm_pkg.
module pmm_seq #(
  parameter int MAX_PILES = pmm_pkg::MAX_PILES_DEF,
  localparam int IW = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1,
  localparam int CW = $clog2(MAX_PILES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CW-1:0]       n_in,
  input  logic                circ,
  input  logic                out_free,
  output logic [IW-1:0]       p_raddr0,
  output logic [IW-1:0]       p_raddr1,
  output logic                c_we,
  output logic [2*IW-1:0]     c_waddr,
  output logic [2*IW-1:0]     c_raddr0,
  output logic [2*IW-1:0]     c_raddr1,
  output pmm_pkg::alu_ctl_t   ctl,
  output pmm_pkg::seq_stat_t  stat
);

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_TOT   = 8'b0000_0010,
    ST_K     = 8'b0000_0100,
    ST_WAIT  = 8'b0000_1000,
    ST_WB    = 8'b0001_0000,
    ST_FIN   = 8'b0010_0000,
    ST_FWAIT = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [IW-1:0] s_r, s_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic          single_r, single_nxt;

  logic [CW:0]   end_idx;
  logic [CW:0]   e_idx;
  logic          wrap;
  logic [IW:0]   j_idx;
  logic [IW:0]   jw;
  logic [CW-1:0] lm_k;
  logic [CW-1:0] nm1;
  logic [CW-1:0] lenm1;
  logic [CW:0]   s_p1;
  logic          row_end;
  logic          k_last;
  logic          fin_last;

  always_comb begin
    end_idx  = (CW+1)'(s_r) + (CW+1)'(len_r);
    wrap     = end_idx >= (CW+1)'(n_r);
    e_idx    = wrap ? (end_idx - (CW+1)'(n_r)) : end_idx;
    j_idx    = (IW+1)'(s_r) + (IW+1)'(k_r);
    jw       = (j_idx >= (IW+1)'(n_r)) ? (j_idx - (IW+1)'(n_r)) : j_idx;
    lm_k     = len_r - CW'(k_r) - CW'(1);
    nm1      = n_r - CW'(1);
    lenm1    = len_r - CW'(1);
    s_p1     = (CW+1)'(s_r) + (CW+1)'(1);
    row_end  = circ ? (s_p1 == (CW+1)'(n_r))
                    : ((s_p1 + (CW+1)'(len_r)) > (CW+1)'(n_r));
    k_last   = (CW'(k_r) + CW'(1)) == len_r;
    fin_last = !circ || (s_p1 == (CW+1)'(n_r));
  end

  always_comb begin
    p_raddr0 = s_r;
    p_raddr1 = e_idx[IW-1:0];
    c_we     = (state_r == ST_WB);
    c_waddr  = {s_r, lenm1[IW-1:0]};
    c_raddr0 = (state_r == ST_FIN) ? {s_r, nm1[IW-1:0]} : {s_r, k_r - IW'(1)};
    c_raddr1 = {jw[IW-1:0], lm_k[IW-1:0]};

    ctl = '0;
    if (state_r == ST_TOT) begin
      ctl.tot  = 1'b1;
      ctl.wrap = wrap;
    end
    if (state_r == ST_K) begin
      ctl.acc   = 1'b1;
      ctl.first = (k_r == IW'(1));
      ctl.za    = (k_r == IW'(1));
      ctl.zb    = (lm_k == '0);
    end
    if (state_r == ST_FIN) begin
      ctl.acc   = 1'b1;
      ctl.first = (s_r == '0);
      ctl.zb    = 1'b1;
    end

    stat.busy     = (state_r != ST_LOAD);
    stat.res_load = (state_r == ST_DONE) && out_free;
    stat.single   = single_r;
  end

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    len_nxt    = len_r;
    s_nxt      = s_r;
    k_nxt      = k_r;
    single_nxt = single_r;
    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          n_nxt      = n_in;
          len_nxt    = CW'(2);
          s_nxt      = '0;
          single_nxt = (n_in <= CW'(1));
          state_nxt  = (n_in <= CW'(1)) ? ST_DONE : ST_TOT;
        end
      end
      ST_TOT: begin
        k_nxt     = IW'(1);
        state_nxt = ST_K;
      end
      ST_K: begin
        if (k_last) begin
          state_nxt = ST_WAIT;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      ST_WAIT: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (row_end) begin
          s_nxt = '0;
          if (len_r == n_r) begin
            state_nxt = ST_FIN;
          end else begin
            len_nxt   = len_r + CW'(1);
            state_nxt = ST_TOT;
          end
        end else begin
          s_nxt     = s_r + IW'(1);
          state_nxt = ST_TOT;
        end
      end
      ST_FIN: begin
        if (fin_last) begin
          state_nxt = ST_FWAIT;
        end else begin
          s_nxt = s_r + IW'(1);
        end
      end
      ST_FWAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      n_r      <= '0;
      len_r    <= '0;
      s_r      <= '0;
      k_r      <= '0;
      single_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      n_r      <= n_nxt;
      len_r    <= len_nxt;
      s_r      <= s_nxt;
      k_r      <= k_nxt;
      single_r <= single_nxt;
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == ST_LOAD))
    else $error("set closed while computing");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K) |-> ((CW'(k_r) < len_r) && (k_r != '0)))
    else $error("split point outside interval");

  a_interval_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TOT) |-> ((len_r <= n_r) && (CW'(s_r) < n_r) && (len_r >= CW'(2))))
    else $error("interval outside loaded piles");

  a_wb_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> ($past(state_r) == ST_WAIT))
    else $error("write-back without finished minimum");
`endif

endmodule

### rtl/core/pile_merge_min_cost.sv
// Least total cost of merging a row (or ring) of piles into one, by interval
// dynamic programming. Depends on pmm_pkg, pmm_ram, pmm_alu and pmm_seq.
//
// Piles load one per cycle while in_tready is high, one item each; the item
// with tlast closes the set (at most MAX_PILES held, extras dropped and
// flagged in out_tuser). Prefix sums are written as piles arrive, so loading
// costs nothing extra. After the last pile the block is not ready while one
// shared add/compare unit fills the cost table: each interval of length L
// passes through a total step, one split step per split point, a wait step
// and a write-back step, the two-port cost table delivering one split pair
// per cycle. One or no pile gives 0. The result sits in an output register,
// and the next set may load while it waits. The working stores need no
// clearing pass.
module pile_merge_min_cost #(
  parameter int MAX_PILES = pmm_pkg::MAX_PILES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] pile_weight
  input  logic        in_tlast,    // last_pile
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] min_cost
  output logic        out_tuser,   // [0] overflowed
  input  logic        cfg_we,
  input  logic        cfg_wdata    // [0] circular_mode
);

  localparam int IW  = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
  localparam int CW  = $clog2(MAX_PILES + 1);
  localparam int PSW = pmm_pkg::WEIGHT_W + IW;
  localparam int CWD = pmm_pkg::COST_W;

  logic           cfg_circ_r;
  logic [CW-1:0]  count_r;
  logic           ovf_r;
  logic           ovf_hold_r;
  logic [PSW-1:0] sum_r;
  logic           out_valid_r;
  logic [CWD-1:0] out_cost_r;
  logic           out_ovf_r;

  logic           acc_in;
  logic           room;
  logic           start;
  logic [CW-1:0]  n_in;
  logic [PSW-1:0] pw_data;
  logic [PSW-1:0] sum_nxt;
  logic           out_free;

  logic [IW-1:0]       p_raddr0, p_raddr1;
  logic [PSW-1:0]      p_rdata0, p_rdata1;
  logic                c_we;
  logic [2*IW-1:0]     c_waddr, c_raddr0, c_raddr1;
  logic [CWD-1:0]      c_rdata0, c_rdata1;
  logic [CWD-1:0]      c_wdata;
  logic [CWD-1:0]      best;
  pmm_pkg::alu_ctl_t   ctl;
  pmm_pkg::seq_stat_t  stat;

  assign in_tready  = !stat.busy;
  assign acc_in     = in_tvalid && in_tready;
  assign room       = (count_r != CW'(MAX_PILES));
  assign start      = acc_in && in_tlast;
  assign n_in       = room ? (count_r + CW'(1)) : count_r;
  assign pw_data    = (count_r == '0) ? '0 : sum_r;
  assign sum_nxt    = pw_data + PSW'(in_tdata);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cost_r;
  assign out_tuser  = out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_circ_r  <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      ovf_hold_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_circ_r <= cfg_wdata;
      end
      if (acc_in) begin
        if (in_tlast) begin
          count_r    <= '0;
          ovf_r      <= 1'b0;
          ovf_hold_r <= ovf_r || !room;
        end else if (room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (stat.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && room) begin
      sum_r <= sum_nxt;
    end
    if (stat.res_load) begin
      out_cost_r <= stat.single ? '0 : best;
      out_ovf_r  <= ovf_hold_r;
    end
  end

  pmm_ram #(
    .W     (PSW),
    .DEPTH (MAX_PILES)
  ) u_prefix (
    .clk    (clk),
    .we     (acc_in && room),
    .waddr  (count_r[IW-1:0]),
    .wdata  (pw_data),
    .raddr0 (p_raddr0),
    .raddr1 (p_raddr1),
    .rdata0 (p_rdata0),
    .rdata1 (p_rdata1)
  );

  pmm_ram #(
    .W     (CWD),
    .DEPTH (2 ** (2 * IW))
  ) u_cost (
    .clk    (clk),
    .we     (c_we),
    .waddr  (c_waddr),
    .wdata  (c_wdata),
    .raddr0 (c_raddr0),
    .raddr1 (c_raddr1),
    .rdata0 (c_rdata0),
    .rdata1 (c_rdata1)
  );

  pmm_seq #(
    .MAX_PILES (MAX_PILES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .n_in     (n_in),
    .circ     (cfg_circ_r),
    .out_free (out_free),
    .p_raddr0 (p_raddr0),
    .p_raddr1 (p_raddr1),
    .c_we     (c_we),
    .c_waddr  (c_waddr),
    .c_raddr0 (c_raddr0),
    .c_raddr1 (c_raddr1),
    .ctl      (ctl),
    .stat     (stat)
  );

  pmm_alu #(
    .PSW (PSW)
  ) u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .p_start (p_rdata0),
    .p_end   (p_rdata1),
    .sum     (sum_r),
    .c_a     (c_rdata0),
    .c_b     (c_rdata1),
    .wdata   (c_wdata),
    .best    (best)
  );

endmodule
